### rtl/core/avr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avr_pkg: shared types and constants of the axis vertex rotator
// Beat structs, the axis codes, the CORDIC arctangent table and gain.
// ----------------------------------------------------------------------------
package avr_pkg;

	localparam int COORD_WIDTH  = 24;
	localparam int ANGLE_WIDTH  = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int TABLE_LEN    = 24;
	localparam int NSTEPS       = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
	localparam int CS_WIDTH     = 34;
	localparam int QDEPTH       = 4;
	localparam int QAW          = $clog2(QDEPTH);

	typedef enum logic [1:0] {
		AXIS_X    = 2'd0,
		AXIS_Y    = 2'd1,
		AXIS_Z    = 2'd2,
		AXIS_NONE = 2'd3
	} axis_t;

	typedef struct packed {
		logic [1:0]                     command;
		logic signed [COORD_WIDTH-1:0]  coord_x;
		logic signed [COORD_WIDTH-1:0]  coord_y;
		logic signed [COORD_WIDTH-1:0]  coord_z;
		logic signed [ANGLE_WIDTH-1:0]  angle;
	} in_beat_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] rot_x;
		logic signed [COORD_WIDTH-1:0] rot_y;
		logic signed [COORD_WIDTH-1:0] rot_z;
		logic                          saturated;
	} out_beat_t;

	// classified item: plane pair (a, b), pass-through axis c, selection
	typedef struct packed {
		axis_t                         axis;
		logic signed [COORD_WIDTH-1:0] a;
		logic signed [COORD_WIDTH-1:0] b;
		logic signed [COORD_WIDTH-1:0] c;
		logic                          flip;
		logic signed [31:0]            z;
	} front_t;

	localparam logic signed [CS_WIDTH-1:0] GAIN_Q30 = CS_WIDTH'(652032874);

	function automatic logic signed [32:0] atan_turn(input int i);
		logic signed [32:0] r;
		case (i)
			0: r = 33'sd536870912;  1: r = 33'sd316933406;
			2: r = 33'sd167458907;  3: r = 33'sd85004756;
			4: r = 33'sd42667331;   5: r = 33'sd21354465;
			6: r = 33'sd10679838;   7: r = 33'sd5340245;
			8: r = 33'sd2670163;    9: r = 33'sd1335087;
			10: r = 33'sd667544;    11: r = 33'sd333772;
			12: r = 33'sd166886;    13: r = 33'sd83443;
			14: r = 33'sd41722;     15: r = 33'sd20861;
			16: r = 33'sd10430;     17: r = 33'sd5215;
			18: r = 33'sd2608;      19: r = 33'sd1304;
			20: r = 33'sd652;       21: r = 33'sd326;
			22: r = 33'sd163;       default: r = 33'sd81;
		endcase
		return r;
	endfunction

endpackage

### rtl/core/avr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avr_front: input stage
// Registers each beat, orders the plane pair by axis and folds the phase
// into the right half-plane.
// ----------------------------------------------------------------------------
module avr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  avr_pkg::in_beat_t in_beat,
	input  logic              stall,
	output logic              out_valid,
	output avr_pkg::front_t   out_item
);
	import avr_pkg::*;

	logic [31:0] ph;
	logic        flip;
	logic [31:0] phf;
	front_t      nxt;

	always_comb begin
		ph   = {in_beat.angle, {(32-ANGLE_WIDTH){1'b0}}};
		flip = ph[31] ^ ph[30];
		phf  = flip ? (ph + 32'h8000_0000) : ph;
		nxt.axis = axis_t'(in_beat.command);
		nxt.flip = flip;
		nxt.z    = $signed(phf);
		unique case (axis_t'(in_beat.command))
			AXIS_X: begin
				nxt.a = in_beat.coord_y; nxt.b = in_beat.coord_z; nxt.c = in_beat.coord_x;
			end
			AXIS_Y: begin
				nxt.a = in_beat.coord_z; nxt.b = in_beat.coord_x; nxt.c = in_beat.coord_y;
			end
			AXIS_Z: begin
				nxt.a = in_beat.coord_x; nxt.b = in_beat.coord_y; nxt.c = in_beat.coord_z;
			end
			default: begin
				nxt.a = in_beat.coord_x; nxt.b = in_beat.coord_y; nxt.c = in_beat.coord_z;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!stall) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall && in_valid) begin
			out_item <= nxt;
		end
	end

endmodule

### rtl/core/avr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avr_queue: small register queue
// Decouples the front stage from the rotation pipeline.
// ----------------------------------------------------------------------------
module avr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  avr_pkg::front_t wdata,
	input  logic            pop,
	output avr_pkg::front_t rdata,
	output logic            empty,
	output logic            afull
);
	import avr_pkg::*;

	front_t        mem_q [QDEPTH];
	logic [QAW-1:0] wp_q;
	logic [QAW-1:0] rp_q;
	logic [QAW:0]   cnt_q;
	logic           do_push;
	logic           do_pop;

	assign empty   = (cnt_q == '0);
	assign afull   = (cnt_q >= (QAW+1)'(QDEPTH - 2));
	assign do_pop  = pop && !empty;
	assign do_push = push;
	assign rdata   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wp_q <= wp_q + 1'b1;
			if (do_pop)  rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
		end
	end

endmodule

### rtl/core/avr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avr_back: rotation pipeline
// One CORDIC step per stage, then the plane products, the rounding and
// saturation, and the output stage.
// ----------------------------------------------------------------------------
module avr_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  avr_pkg::front_t  in_item,
	input  logic             stall,
	output logic             out_valid,
	output avr_pkg::out_beat_t out_beat
);
	import avr_pkg::*;

	localparam int PW = CS_WIDTH + COORD_WIDTH;
	localparam int SW = PW + 1;

	logic                       v_q   [1:NSTEPS];
	front_t                     it_q  [1:NSTEPS];
	logic signed [CS_WIDTH-1:0] cx_q  [1:NSTEPS];
	logic signed [CS_WIDTH-1:0] cy_q  [1:NSTEPS];
	logic signed [32:0]         cz_q  [1:NSTEPS];

	for (genvar i = 0; i < NSTEPS; i++) begin : g_step
		logic                       v_i;
		front_t                     it_i;
		logic signed [CS_WIDTH-1:0] x_i, y_i;
		logic signed [32:0]         z_i;
		logic signed [CS_WIDTH-1:0] dx, dy;
		if (i == 0) begin : g_first
			assign v_i  = in_valid;
			assign it_i = in_item;
			assign x_i  = GAIN_Q30;
			assign y_i  = '0;
			assign z_i  = 33'(in_item.z);
		end else begin : g_next
			assign v_i  = v_q[i];
			assign it_i = it_q[i];
			assign x_i  = cx_q[i];
			assign y_i  = cy_q[i];
			assign z_i  = cz_q[i];
		end
		assign dx = y_i >>> i;
		assign dy = x_i >>> i;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[i+1] <= 1'b0;
			end else if (!stall) begin
				v_q[i+1] <= v_i;
			end
		end
		always_ff @(posedge clk) begin
			if (!stall) begin
				it_q[i+1] <= it_i;
				if (!z_i[32]) begin
					cx_q[i+1] <= x_i - dx;
					cy_q[i+1] <= y_i + dy;
					cz_q[i+1] <= z_i - atan_turn(i);
				end else begin
					cx_q[i+1] <= x_i + dx;
					cy_q[i+1] <= y_i - dy;
					cz_q[i+1] <= z_i + atan_turn(i);
				end
			end
		end
	end

	// products
	logic signed [CS_WIDTH-1:0] cc, ss;
	assign cc = it_q[NSTEPS].flip ? -cx_q[NSTEPS] : cx_q[NSTEPS];
	assign ss = it_q[NSTEPS].flip ? -cy_q[NSTEPS] : cy_q[NSTEPS];

	logic                  v_s1;
	front_t                it_s1;
	logic signed [PW-1:0]  ca_s1, sb_s1, sa_s1, cb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (!stall) v_s1 <= v_q[NSTEPS];
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			it_s1 <= it_q[NSTEPS];
			ca_s1 <= PW'(cc * it_q[NSTEPS].a);
			sb_s1 <= PW'(ss * it_q[NSTEPS].b);
			sa_s1 <= PW'(ss * it_q[NSTEPS].a);
			cb_s1 <= PW'(cc * it_q[NSTEPS].b);
		end
	end

	// sums and rounding
	logic signed [SW-1:0] na_sum, nb_sum;
	logic signed [SW-31:0] na_r, nb_r;
	logic                 v_s2;
	front_t               it_s2;
	logic signed [SW-31:0] na_s2, nb_s2;

	assign na_sum = SW'(ca_s1) - SW'(sb_s1) + SW'(64'sd1 <<< 29);
	assign nb_sum = SW'(sa_s1) + SW'(cb_s1) + SW'(64'sd1 <<< 29);
	assign na_r   = na_sum[SW-1:30];
	assign nb_r   = nb_sum[SW-1:30];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (!stall) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			it_s2 <= it_s1;
			na_s2 <= na_r;
			nb_s2 <= nb_r;
		end
	end

	// saturation and reorder
	localparam logic signed [SW-31:0] HI = (SW-30)'((64'sd1 <<< (COORD_WIDTH-1)) - 1);
	localparam logic signed [SW-31:0] LO = -HI - 1;

	logic signed [COORD_WIDTH-1:0] ra, rb;
	logic                          sa_f, sb_f;
	out_beat_t                     nb;

	always_comb begin
		sa_f = 1'b0;
		sb_f = 1'b0;
		if (na_s2 > HI) begin
			ra = HI[COORD_WIDTH-1:0]; sa_f = 1'b1;
		end else if (na_s2 < LO) begin
			ra = LO[COORD_WIDTH-1:0]; sa_f = 1'b1;
		end else begin
			ra = na_s2[COORD_WIDTH-1:0];
		end
		if (nb_s2 > HI) begin
			rb = HI[COORD_WIDTH-1:0]; sb_f = 1'b1;
		end else if (nb_s2 < LO) begin
			rb = LO[COORD_WIDTH-1:0]; sb_f = 1'b1;
		end else begin
			rb = nb_s2[COORD_WIDTH-1:0];
		end
		nb.saturated = sa_f | sb_f;
		unique case (it_s2.axis)
			AXIS_X: begin
				nb.rot_x = it_s2.c; nb.rot_y = ra; nb.rot_z = rb;
			end
			AXIS_Y: begin
				nb.rot_x = rb; nb.rot_y = it_s2.c; nb.rot_z = ra;
			end
			AXIS_Z: begin
				nb.rot_x = ra; nb.rot_y = rb; nb.rot_z = it_s2.c;
			end
			default: begin
				nb.rot_x = it_s2.a; nb.rot_y = it_s2.b; nb.rot_z = it_s2.c;
				nb.saturated = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (!stall) out_valid <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (!stall) out_beat <= nb;
	end

endmodule

### rtl/core/axis_vertex_rotator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_vertex_rotator: vertex rotation about one coordinate axis
// Takes one vertex beat per cycle while full is low and returns it rotated,
// rounded and saturated, with a flag for any clipped component.
// ----------------------------------------------------------------------------
// One beat is accepted per cycle while full is low, and one result leaves per
// cycle while pop is high. Each beat passes one front register, one queue slot,
// one CORDIC stage per step, one product stage, one rounding stage and the
// output register. The front stage fills a four-entry queue; full rises when
// two entries are in use, so beats in flight always find room. The rotation
// pipeline advances whenever its output register is empty or being popped.
// ----------------------------------------------------------------------------
module axis_vertex_rotator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  avr_pkg::in_beat_t  in_beat,
	output logic               empty,
	input  logic               pop,
	output avr_pkg::out_beat_t out_beat
);
	import avr_pkg::*;

	logic   fv;
	front_t fi;
	logic   q_empty, q_afull;
	front_t qd;
	logic   bv;
	logic   bstall;
	logic   q_pop;

	assign full = q_afull;

	avr_front u_front (
		.clk, .arst_n,
		.in_valid (push && !full),
		.in_beat,
		.stall    (1'b0),
		.out_valid(fv),
		.out_item (fi)
	);

	assign bstall = bv && !pop;
	assign q_pop  = !bstall && !q_empty;

	avr_queue u_queue (
		.clk, .arst_n,
		.push (fv),
		.wdata(fi),
		.pop  (q_pop),
		.rdata(qd),
		.empty(q_empty),
		.afull(q_afull)
	);

	avr_back u_back (
		.clk, .arst_n,
		.in_valid (q_pop),
		.in_item  (qd),
		.stall    (bstall),
		.out_valid(bv),
		.out_beat
	);

	assign empty = !bv;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_beat)))
		else $error("result changed while waiting");
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({full, empty}))
		else $error("unknown handshake");
	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!(fv && q_empty == 1'b0 && q_afull && u_queue.cnt_q == (QAW+1)'(QDEPTH)))
		else $error("queue overflow");

endmodule
